[sv/sevm_pkg.sv]
// Shared types, constants and helpers for the smoothed Euler view matrix block.
// No dependencies.
package sevm_pkg;

    localparam int CORDIC_TABLE_LEN = 24;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [1:0] {
        REG_SMOOTH_ENABLE = 2'd0,
        REG_POS_SMOOTHNESS = 2'd1,
        REG_ROT_SMOOTHNESS = 2'd2
    } cfg_index_t;

    // Operations the controller may request from the datapath.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_FACTOR  = 4'd2,
        OP_BLEND   = 4'd3,
        OP_SELECT  = 4'd4,
        OP_TRIG    = 4'd5,
        OP_PROD    = 4'd6,
        OP_ELEM    = 4'd7,
        OP_TRANS   = 4'd8,
        OP_OUTPUT  = 4'd9
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [4:0]  idx;
        logic [3:0]  sub;
        logic        seed;
    } dp_cmd_t;

    typedef struct packed {
        logic smooth;
        logic seeded;
    } dp_status_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0: r = 34'sd536870912;
                5'd1: r = 34'sd316933406;
                5'd2: r = 34'sd167458907;
                5'd3: r = 34'sd85004756;
                5'd4: r = 34'sd42667331;
                5'd5: r = 34'sd21354465;
                5'd6: r = 34'sd10679838;
                5'd7: r = 34'sd5340245;
                5'd8: r = 34'sd2670163;
                5'd9: r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

[sv/sevm_ctrl.sv]
// Sequencer for the smoothed Euler view matrix block.
// Depends on sevm_pkg.
module sevm_ctrl #(
    parameter int ITERS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  sevm_pkg::dp_status_t  status,
    output sevm_pkg::dp_cmd_t     cmd
);
    import sevm_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_FACTOR = 10'b0000000010,
        ST_BLEND  = 10'b0000000100,
        ST_SELECT = 10'b0000001000,
        ST_TRIG   = 10'b0000010000,
        ST_PROD   = 10'b0000100000,
        ST_ELEM   = 10'b0001000000,
        ST_TRANS  = 10'b0010000000,
        ST_OUT    = 10'b0100000000,
        ST_HOLD   = 10'b1000000000
    } state_t;

    localparam int N_IT = (ITERS > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : ITERS;

    state_t state_reg, state_next;
    logic [4:0] idx_reg, idx_next;
    logic [3:0] sub_reg, sub_next;
    logic       seed_reg, seed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            sub_reg <= '0;
            seed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            sub_reg <= sub_next;
            seed_reg <= seed_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        sub_next = sub_reg;
        seed_next = seed_reg;
        cmd = '{op: OP_NONE, idx: idx_reg, sub: sub_reg, seed: seed_reg};
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    seed_next = !status.seeded;
                    state_next = status.smooth ? ST_FACTOR : ST_SELECT;
                end
            end
            ST_FACTOR: begin
                cmd.op = OP_FACTOR;
                sub_next = '0;
                state_next = ST_BLEND;
            end
            // One axis of position or angle per cycle: sub 0..2 position, 3..5 angle.
            ST_BLEND: begin
                cmd.op = OP_BLEND;
                if (sub_reg == 4'd5) begin
                    sub_next = '0;
                    state_next = ST_SELECT;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_SELECT: begin
                cmd.op = OP_SELECT;
                idx_next = '0;
                state_next = ST_TRIG;
            end
            ST_TRIG: begin
                cmd.op = OP_TRIG;
                if (idx_reg == 5'(N_IT - 1)) begin
                    idx_next = '0;
                    sub_next = '0;
                    state_next = ST_PROD;
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            // The first cycle latches sine and cosine, then one product of two Q1.14
            // terms per cycle.
            ST_PROD: begin
                cmd.op = OP_PROD;
                if (sub_reg == 4'd12) begin
                    sub_next = '0;
                    state_next = ST_ELEM;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_ELEM: begin
                cmd.op = OP_ELEM;
                if (sub_reg == 4'd8) begin
                    sub_next = '0;
                    state_next = ST_TRANS;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_TRANS: begin
                cmd.op = OP_TRANS;
                if (sub_reg == 4'd8) begin
                    sub_next = '0;
                    state_next = ST_OUT;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_OUT: begin
                cmd.op = OP_OUTPUT;
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/sevm_datapath.sv]
// Datapath: pose registers, blend unit, three CORDIC lanes, shared multiplier.
// Depends on sevm_pkg.
module sevm_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    input  sevm_pkg::dp_cmd_t          cmd,
    output sevm_pkg::dp_status_t       status,
    input  logic signed [31:0]         in_pos [3],
    input  logic signed [15:0]         in_ang [3],
    input  logic [15:0]                in_dt,
    output logic signed [15:0]         row_out [9],
    output logic signed [31:0]         trans_out [3]
);
    import sevm_pkg::*;

    logic        smooth_reg;
    logic [15:0] psm_reg, rsm_reg;
    logic signed [31:0] cur_pos_reg [3];
    logic signed [15:0] cur_ang_reg [3];
    logic        seeded_reg;

    logic signed [31:0] tp_reg [3];
    logic signed [15:0] ta_reg [3];
    logic [15:0] dt_reg;
    logic [31:0] fp_reg, fr_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [33:0] cx_reg [3], cy_reg [3], cz_reg [3];
    logic        flip_reg [3];

    logic signed [15:0] sv_reg [3], cv_reg [3];   // Q1.14: index 0 roll, 1 pitch, 2 yaw
    logic signed [29:0] pr_reg [12];
    logic signed [15:0] el_reg [9];
    logic signed [63:0] acc_reg;
    logic signed [31:0] tr_reg [3];
    logic signed [15:0] ro_reg [9];
    logic signed [31:0] to_reg [3];

    assign status = '{smooth: smooth_reg, seeded: seeded_reg};
    assign row_out = ro_reg;
    assign trans_out = to_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= 1'b0;
            psm_reg <= 16'd2560;
            rsm_reg <= 16'd2560;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SMOOTH_ENABLE: smooth_reg <= cfg_data[0];
                REG_POS_SMOOTHNESS: psm_reg <= cfg_data;
                REG_ROT_SMOOTHNESS: rsm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Blend of one axis: cur + floor(diff * f / 2^24).
    logic [1:0]  bax;
    logic        bang;
    logic signed [32:0] bcur, btgt, bdiff;
    logic signed [66:0] bprod;
    logic signed [42:0] bdelta;
    logic signed [43:0] bsum;
    logic signed [31:0] bpos_new;
    logic signed [15:0] bang_new;

    always_comb begin
        bang = (cmd.sub >= 4'd3);
        bax = bang ? 2'(cmd.sub - 4'd3) : cmd.sub[1:0];
        if (bang) begin
            bcur = cmd.seed ? 33'(ta_reg[bax[1:0]]) : 33'(cur_ang_reg[bax[1:0]]);
            btgt = 33'(ta_reg[bax[1:0]]);
            bdiff = btgt - bcur;
            bprod = 67'(bdiff) * $signed({35'd0, fr_reg});
        end else begin
            bcur = cmd.seed ? 33'(tp_reg[bax[1:0]]) : 33'(cur_pos_reg[bax[1:0]]);
            btgt = 33'(tp_reg[bax[1:0]]);
            bdiff = btgt - bcur;
            bprod = 67'(bdiff) * $signed({35'd0, fp_reg});
        end
        bdelta = 43'(bprod >>> 24);
        bsum = 44'(bcur) + 44'(bdelta);
        if (bsum > 44'sd2147483647) bpos_new = 32'sh7fffffff;
        else if (bsum < -44'sd2147483648) bpos_new = 32'sh80000000;
        else bpos_new = bsum[31:0];
        bang_new = bsum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                cur_pos_reg[i] <= '0;
                cur_ang_reg[i] <= '0;
            end
        end else if (cmd.op == OP_BLEND) begin
            seeded_reg <= 1'b1;
            if (bang) cur_ang_reg[bax[1:0]] <= bang_new;
            else cur_pos_reg[bax[1:0]] <= bpos_new;
        end
    end

    // CORDIC lanes for roll, pitch and yaw.
    logic signed [15:0] sel_ang [3];
    logic signed [16:0] red_ang [3];
    logic               red_flip [3];
    logic signed [15:0] tq_s [3], tq_c [3];
    logic signed [33:0] xs [3], ys [3];
    logic signed [34:0] rx [3], ry [3];

    always_comb begin
        sel_ang[0] = smooth_reg ? cur_ang_reg[2] : ta_reg[2];
        sel_ang[1] = smooth_reg ? cur_ang_reg[0] : ta_reg[0];
        sel_ang[2] = smooth_reg ? cur_ang_reg[1] : ta_reg[1];
        for (int k = 0; k < 3; k++) begin
            red_flip[k] = 1'b0;
            red_ang[k] = 17'(sel_ang[k]);
            if (sel_ang[k] > 16'sd16384) begin
                red_ang[k] = 17'(sel_ang[k]) - 17'sd32768;
                red_flip[k] = 1'b1;
            end else if (sel_ang[k] < -16'sd16384) begin
                red_ang[k] = 17'(sel_ang[k]) + 17'sd32768;
                red_flip[k] = 1'b1;
            end
            xs[k] = cx_reg[k] >>> cmd.idx;
            ys[k] = cy_reg[k] >>> cmd.idx;
            rx[k] = flip_reg[k] ? -35'(cx_reg[k]) : 35'(cx_reg[k]);
            ry[k] = flip_reg[k] ? -35'(cy_reg[k]) : 35'(cy_reg[k]);
            rx[k] = (rx[k] + 35'sd32768) >>> 16;
            ry[k] = (ry[k] + 35'sd32768) >>> 16;
            if (rx[k] > 35'sd16384) tq_c[k] = 16'sd16384;
            else if (rx[k] < -35'sd16384) tq_c[k] = -16'sd16384;
            else tq_c[k] = rx[k][15:0];
            if (ry[k] > 35'sd16384) tq_s[k] = 16'sd16384;
            else if (ry[k] < -35'sd16384) tq_s[k] = -16'sd16384;
            else tq_s[k] = ry[k][15:0];
        end
    end

    // Product operand selection; s/c index: 0 roll(3), 1 pitch(2), 2 yaw(1).
    // Product slot n is formed in product step n + 1; step 0 latches sine and cosine.
    logic [3:0]         msel;
    logic signed [15:0] ma, mb;
    logic signed [31:0] mprod;
    always_comb begin
        ma = '0;
        mb = '0;
        msel = cmd.sub - 4'd1;
        case (msel)
            4'd0: begin ma = cv_reg[2]; mb = cv_reg[0]; end   // c1c3
            4'd1: begin ma = sv_reg[2]; mb = sv_reg[1]; end   // s1s2
            4'd2: begin ma = cv_reg[1]; mb = sv_reg[0]; end   // c2s3
            4'd3: begin ma = cv_reg[2]; mb = sv_reg[1]; end   // c1s2
            4'd4: begin ma = cv_reg[0]; mb = sv_reg[2]; end   // c3s1
            4'd5: begin ma = cv_reg[0]; mb = sv_reg[1]; end   // c3s2 (unused product slot kept)
            4'd6: begin ma = cv_reg[2]; mb = sv_reg[0]; end   // c1s3
            4'd7: begin ma = cv_reg[1]; mb = cv_reg[0]; end   // c2c3
            4'd8: begin ma = sv_reg[2]; mb = sv_reg[0]; end   // s1s3
            4'd9: begin ma = cv_reg[1]; mb = sv_reg[2]; end   // c2s1
            4'd10: begin ma = cv_reg[2]; mb = cv_reg[1]; end  // c1c2
            4'd11: begin ma = -sv_reg[1]; mb = 16'sd16384; end
            default: ;
        endcase
        mprod = ma * mb;
    end

    // Element sums in Q3.42 built from Q2.28 products times a Q1.14 third factor.
    logic signed [15:0] ef;
    logic signed [29:0] ep0, ep1;
    logic               etwo, eneg;
    logic signed [47:0] esum;
    logic signed [47:0] er;
    logic signed [15:0] eq;
    always_comb begin
        ef = 16'sd16384;
        ep0 = pr_reg[0];
        ep1 = '0;
        etwo = 1'b0;
        eneg = 1'b0;
        case (cmd.sub)
            4'd0: begin ep0 = pr_reg[0]; ep1 = pr_reg[1]; etwo = 1'b1; end
            4'd1: begin ep0 = pr_reg[2]; end
            4'd2: begin ep0 = pr_reg[3]; ep1 = pr_reg[4]; etwo = 1'b1; eneg = 1'b1; end
            4'd3: begin ep0 = pr_reg[5]; ep1 = pr_reg[6]; etwo = 1'b1; eneg = 1'b1; end
            4'd4: begin ep0 = pr_reg[7]; end
            4'd5: begin ep0 = pr_reg[3]; ep1 = pr_reg[8]; etwo = 1'b1; end
            4'd6: begin ep0 = pr_reg[9]; end
            4'd7: begin ep0 = pr_reg[11]; end
            4'd8: begin ep0 = pr_reg[10]; end
            default: ;
        endcase
        // Three-factor term uses the listed third factor.
        case (cmd.sub)
            4'd0: ef = sv_reg[0];      // s1s2 * s3 on pr1
            4'd2: ef = sv_reg[0];      // c1s2 * s3 on pr3
            4'd3: ef = sv_reg[1];      // c3s1 * s2 on pr4
            4'd5: ef = cv_reg[0];      // c1s2 * c3 on pr3
            default: ef = 16'sd16384;
        endcase
        esum = '0;
        case (cmd.sub)
            4'd0: esum = 48'(ep0) * 48'sd16384 + 48'(ep1) * 48'(ef);
            4'd2: esum = 48'(ep0) * 48'(ef) - 48'(ep1) * 48'sd16384;
            4'd3: esum = 48'(pr_reg[4]) * 48'(sv_reg[1]) - 48'(ep1) * 48'sd16384;
            4'd5: esum = 48'(ep0) * 48'(ef) + 48'(ep1) * 48'sd16384;
            default: esum = 48'(ep0) * 48'sd16384;
        endcase
        er = (esum + 48'sd134217728) >>> 28;
        if (er > 48'sd16384) eq = 16'sd16384;
        else if (er < -48'sd16384) eq = -16'sd16384;
        else eq = er[15:0];
    end

    // Translation: one element-by-coordinate product a cycle into a 64-bit accumulator.
    logic [1:0] trow, tcol;
    logic signed [47:0] tprod;
    logic signed [63:0] tacc, tneg, tsh;
    always_comb begin
        case (cmd.sub)
            4'd0: begin trow = 2'd0; tcol = 2'd0; end
            4'd1: begin trow = 2'd0; tcol = 2'd1; end
            4'd2: begin trow = 2'd0; tcol = 2'd2; end
            4'd3: begin trow = 2'd1; tcol = 2'd0; end
            4'd4: begin trow = 2'd1; tcol = 2'd1; end
            4'd5: begin trow = 2'd1; tcol = 2'd2; end
            4'd6: begin trow = 2'd2; tcol = 2'd0; end
            4'd7: begin trow = 2'd2; tcol = 2'd1; end
            4'd8: begin trow = 2'd2; tcol = 2'd2; end
            default: begin trow = 2'd0; tcol = 2'd0; end
        endcase
        tprod = 48'(el_reg[cmd.sub]) * 48'(pos_reg[tcol]);
        tacc = (tcol == 2'd0) ? 64'(tprod) : acc_reg + 64'(tprod);
        tneg = -tacc + 64'sd8192;
        tsh = tneg >>> 14;
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                tp_reg <= in_pos;
                ta_reg <= in_ang;
                dt_reg <= in_dt;
            end
            OP_FACTOR: begin
                fp_reg <= psm_reg * dt_reg;
                fr_reg <= rsm_reg * dt_reg;
            end
            OP_SELECT: begin
                for (int k = 0; k < 3; k++) begin
                    pos_reg[k] <= smooth_reg ? cur_pos_reg[k] : tp_reg[k];
                    cx_reg[k] <= CORDIC_GAIN_Q30;
                    cy_reg[k] <= '0;
                    cz_reg[k] <= 34'(red_ang[k]) <<< 16;
                    flip_reg[k] <= red_flip[k];
                end
            end
            OP_TRIG: begin
                for (int k = 0; k < 3; k++) begin
                    if (cz_reg[k] >= 0) begin
                        cx_reg[k] <= cx_reg[k] - ys[k];
                        cy_reg[k] <= cy_reg[k] + xs[k];
                        cz_reg[k] <= cz_reg[k] - atan_entry(cmd.idx);
                    end else begin
                        cx_reg[k] <= cx_reg[k] + ys[k];
                        cy_reg[k] <= cy_reg[k] - xs[k];
                        cz_reg[k] <= cz_reg[k] + atan_entry(cmd.idx);
                    end
                end
            end
            OP_PROD: begin
                if (cmd.sub == 4'd0) begin
                    for (int k = 0; k < 3; k++) begin
                        sv_reg[k] <= tq_s[k];
                        cv_reg[k] <= tq_c[k];
                    end
                end else begin
                    pr_reg[msel] <= 30'(mprod);
                end
            end
            OP_ELEM: begin
                el_reg[cmd.sub] <= eq;
            end
            OP_TRANS: begin
                acc_reg <= tacc;
                if (tcol == 2'd2) begin
                    if (tsh > 64'sd2147483647) tr_reg[trow] <= 32'sh7fffffff;
                    else if (tsh < -64'sd2147483648) tr_reg[trow] <= 32'sh80000000;
                    else tr_reg[trow] <= tsh[31:0];
                end
            end
            OP_OUTPUT: begin
                ro_reg <= el_reg;
                to_reg <= tr_reg;
            end
            default: ;
        endcase
    end

endmodule

[sv/smoothed_euler_view_matrix.sv]
// Top level of the smoothed Euler view matrix block.
// Depends on sevm_pkg, sevm_ctrl and sevm_datapath.
//
//   channel  | handshake         | payload
//   s_       | s_valid / s_ready | target position, angles, time step
//   m_       | m_valid / m_ready | rows u, v, w and translation
//   cfg      | cfg_wr_en         | cfg_index, cfg_data
//
// In smooth mode the factor and blend steps come ahead of the CORDIC iterations; the
// elements and the translation are formed one product a cycle.
// Reset restores register defaults and clears the kept pose.
// A result waits in the output register until m_ready; no new item is taken meanwhile.
module smoothed_euler_view_matrix #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_target_pos_x,
    input  logic signed [31:0] s_target_pos_y,
    input  logic signed [31:0] s_target_pos_z,
    input  logic signed [15:0] s_target_pitch,
    input  logic signed [15:0] s_target_yaw,
    input  logic signed [15:0] s_target_roll,
    input  logic [15:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_y,
    output logic signed [15:0] m_right_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    output logic signed [15:0] m_fwd_x,
    output logic signed [15:0] m_fwd_y,
    output logic signed [15:0] m_fwd_z,
    output logic signed [31:0] m_trans_u,
    output logic signed [31:0] m_trans_v,
    output logic signed [31:0] m_trans_w
);
    import sevm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic signed [31:0] in_pos [3];
    logic signed [15:0] in_ang [3];
    logic signed [15:0] row_out [9];
    logic signed [31:0] trans_out [3];

    assign in_pos[0] = s_target_pos_x;
    assign in_pos[1] = s_target_pos_y;
    assign in_pos[2] = s_target_pos_z;
    assign in_ang[0] = s_target_pitch;
    assign in_ang[1] = s_target_yaw;
    assign in_ang[2] = s_target_roll;

    sevm_ctrl #(.ITERS(TRIG_ITERATIONS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    sevm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .status(status),
        .in_pos(in_pos), .in_ang(in_ang), .in_dt(s_time_step),
        .row_out(row_out), .trans_out(trans_out)
    );

    assign m_right_x = row_out[0];
    assign m_right_y = row_out[1];
    assign m_right_z = row_out[2];
    assign m_up_x = row_out[3];
    assign m_up_y = row_out[4];
    assign m_up_z = row_out[5];
    assign m_fwd_x = row_out[6];
    assign m_fwd_y = row_out[7];
    assign m_fwd_z = row_out[8];
    assign m_trans_u = trans_out[0];
    assign m_trans_v = trans_out[1];
    assign m_trans_w = trans_out[2];

endmodule

[test/tb_smoothed_euler_view_matrix.sv]
// Self-checking testbench for smoothed_euler_view_matrix: a built-in pose and matrix
// predictor checks every result transfer. Depends on sevm_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_smoothed_euler_view_matrix;
    import sevm_pkg::*;

    localparam int TRIG_N = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] pitch, yaw, roll;
        logic [15:0]        dt;
    } move_t;

    typedef struct packed {
        logic signed [15:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
        logic signed [31:0] tu, tv, tw;
    } view_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    move_t s_move = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    view_t m_view;

    // Predictor state: register copies and the kept camera pose.
    logic        mdl_smooth;
    logic [15:0] mdl_pos_rate, mdl_rot_rate;
    longint      mdl_pos[3];
    longint      mdl_ang[3];
    logic        mdl_seeded;

    view_t  expected_views[$];
    int     mismatches = 0;
    longint cycle_count = 0;
    bit     rx_idle_on = 1'b1;
    bit     rx_hold = 1'b0;

    smoothed_euler_view_matrix #(.TRIG_ITERATIONS(TRIG_N)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_target_pos_x(s_move.px), .s_target_pos_y(s_move.py),
        .s_target_pos_z(s_move.pz), .s_target_pitch(s_move.pitch),
        .s_target_yaw(s_move.yaw), .s_target_roll(s_move.roll),
        .s_time_step(s_move.dt),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_right_x(m_view.ux), .m_right_y(m_view.uy), .m_right_z(m_view.uz),
        .m_up_x(m_view.vx), .m_up_y(m_view.vy), .m_up_z(m_view.vz),
        .m_fwd_x(m_view.wx), .m_fwd_y(m_view.wy), .m_fwd_z(m_view.wz),
        .m_trans_u(m_view.tu), .m_trans_v(m_view.tv), .m_trans_w(m_view.tw)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint floor_div(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint blend_position(longint cur, longint tgt, longint f);
        longint diff, a, b, aq, ar;
        diff = tgt - cur;
        a = diff * (f >> 16);
        b = diff * (f & 'hFFFF);
        aq = floor_div(a, 8);
        ar = a - aq * 256;
        return clip(cur + aq + floor_div(ar * 65536 + b, 24),
                    -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint blend_angle(longint cur, longint tgt, longint f);
        logic signed [15:0] r;
        r = 16'(cur + floor_div((tgt - cur) * f, 24));
        return longint'(r);
    endfunction

    // Rotation-mode CORDIC giving Q1.14 sine and cosine of a binary angle.
    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint a, x, y, z, nx;
        bit flip;
        a = ang;
        flip = 1'b0;
        x = CORDIC_GAIN_Q30;
        y = 0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1'b1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1'b1;
        end
        z = a * 65536;
        for (int i = 0; i < (TRIG_N > 24 ? 24 : TRIG_N); i++) begin
            if (z >= 0) begin
                nx = x - floor_div(y, i);
                y = y + floor_div(x, i);
                z -= longint'(atan_entry(5'(i)));
            end else begin
                nx = x + floor_div(y, i);
                y = y - floor_div(x, i);
                z += longint'(atan_entry(5'(i)));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip(floor_div(x + 32768, 16), -16384, 16384);
        s = clip(floor_div(y + 32768, 16), -16384, 16384);
    endfunction

    function automatic longint row_elem(longint q42);
        return clip(floor_div(q42 + (64'sd1 <<< 27), 28), -16384, 16384);
    endfunction

    function automatic logic [31:0] translation(longint r0, longint r1, longint r2,
                                               longint p[3]);
        longint sum;
        sum = r0 * p[0] + r1 * p[1] + r2 * p[2];
        return 32'(clip(floor_div(-sum + 8192, 14), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function automatic view_t predict_view(move_t mv);
        longint tp[3], ta[3], p[3], an[3];
        longint fp, fr, s1, c1, s2, c2, s3, c3;
        longint u[3], v[3], w[3];
        view_t r;
        tp[0] = mv.px; tp[1] = mv.py; tp[2] = mv.pz;
        ta[0] = mv.pitch; ta[1] = mv.yaw; ta[2] = mv.roll;
        if (mdl_smooth) begin
            fp = longint'(32'(mdl_pos_rate * mv.dt));
            fr = longint'(32'(mdl_rot_rate * mv.dt));
            if (!mdl_seeded) begin
                mdl_pos = tp;
                mdl_ang = ta;
                mdl_seeded = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                mdl_pos[i] = blend_position(mdl_pos[i], tp[i], fp);
                mdl_ang[i] = blend_angle(mdl_ang[i], ta[i], fr);
            end
            p = mdl_pos;
            an = mdl_ang;
        end else begin
            p = tp;
            an = ta;
        end
        sin_cos(an[2], s3, c3);
        sin_cos(an[0], s2, c2);
        sin_cos(an[1], s1, c1);
        u[0] = row_elem(c1 * c3 * 16384 + s1 * s2 * s3);
        u[1] = row_elem(c2 * s3 * 16384);
        u[2] = row_elem(c1 * s2 * s3 - c3 * s1 * 16384);
        v[0] = row_elem(c3 * s1 * s2 - c1 * s3 * 16384);
        v[1] = row_elem(c2 * c3 * 16384);
        v[2] = row_elem(c1 * c3 * s2 + s1 * s3 * 16384);
        w[0] = row_elem(c2 * s1 * 16384);
        w[1] = row_elem(-s2 * 16384 * 16384);
        w[2] = row_elem(c1 * c2 * 16384);
        r.ux = 16'(u[0]); r.uy = 16'(u[1]); r.uz = 16'(u[2]);
        r.vx = 16'(v[0]); r.vy = 16'(v[1]); r.vz = 16'(v[2]);
        r.wx = 16'(w[0]); r.wy = 16'(w[1]); r.wz = 16'(w[2]);
        r.tu = translation(u[0], u[1], u[2], p);
        r.tv = translation(v[0], v[1], v[2], p);
        r.tw = translation(w[0], w[1], w[2], p);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    // Receiver: random back-pressure, plus a long hold when asked.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (rx_hold) begin
                m_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checks each result transfer against the oldest expected view.
    always @(posedge aclk) begin
        view_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_views.pop_front();
                if (m_view.ux !== e.ux) report_mismatch("right_x", m_view.ux, e.ux);
                if (m_view.uy !== e.uy) report_mismatch("right_y", m_view.uy, e.uy);
                if (m_view.uz !== e.uz) report_mismatch("right_z", m_view.uz, e.uz);
                if (m_view.vx !== e.vx) report_mismatch("up_x", m_view.vx, e.vx);
                if (m_view.vy !== e.vy) report_mismatch("up_y", m_view.vy, e.vy);
                if (m_view.vz !== e.vz) report_mismatch("up_z", m_view.vz, e.vz);
                if (m_view.wx !== e.wx) report_mismatch("fwd_x", m_view.wx, e.wx);
                if (m_view.wy !== e.wy) report_mismatch("fwd_y", m_view.wy, e.wy);
                if (m_view.wz !== e.wz) report_mismatch("fwd_z", m_view.wz, e.wz);
                if (m_view.tu !== e.tu) report_mismatch("trans_u", m_view.tu, e.tu);
                if (m_view.tv !== e.tv) report_mismatch("trans_v", m_view.tv, e.tv);
                if (m_view.tw !== e.tw) report_mismatch("trans_w", m_view.tw, e.tw);
            end
        end
    end

    // Valid is dropped on a falling edge after the transfer and the task returns only on a
    // later falling edge, so the next call never drives valid in the same time step.
    task automatic send_move(move_t mv, bit allow_gap);
        if (allow_gap && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_move <= mv;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_views.push_back(predict_view(mv));
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_views.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_SMOOTH_ENABLE:  mdl_smooth = val[0];
            REG_POS_SMOOTHNESS: mdl_pos_rate = val;
            REG_ROT_SMOOTHNESS: mdl_rot_rate = val;
            default: ;
        endcase
    endtask

    function automatic move_t random_move(bit near);
        move_t mv;
        mv = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom)};
        if (near) begin
            // A modest x position and time step keep the blend from saturating all the time.
            mv.px = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
            mv.dt = 16'($urandom_range(0, 2000));
        end
        return mv;
    endfunction

    task automatic test_direct_extremes();
        logic signed [31:0] p_ext[4] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 0, -1};
        logic signed [15:0] a_ext[8] = '{16'sh7FFF, -16'sh8000, 0, 16'sh4000, -16'sh4000,
                                         16'sh4001, -16'sh4001, 16'sh2000};
        move_t mv;
        for (int i = 0; i < 8; i++) begin
            mv.px = p_ext[i % 4]; mv.py = p_ext[(i + 1) % 4]; mv.pz = p_ext[(i + 2) % 4];
            mv.pitch = a_ext[i]; mv.yaw = a_ext[(i + 3) % 8]; mv.roll = a_ext[(i + 5) % 8];
            mv.dt = (i % 2) ? 16'hFFFF : 16'h0000;
            send_move(mv, 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_smooth_snap_and_blend();
        move_t mv;
        write_reg(REG_SMOOTH_ENABLE, 16'd1);
        for (int i = 0; i < 10; i++) begin
            mv = random_move(1'b1);
            if (i == 3) mv.dt = 16'hFFFF;
            send_move(mv, 1'b0);
        end
        wait_drained();
        write_reg(REG_POS_SMOOTHNESS, 16'hFFFF);
        write_reg(REG_ROT_SMOOTHNESS, 16'h0000);
        for (int i = 0; i < 5; i++) send_move(random_move(i % 2), 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure_fill();
        rx_hold = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_move(random_move(1'b1), 1'b0);
            end
            begin
                repeat (600) @(negedge aclk);
                rx_hold = 1'b0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [15:0] rates[4] = '{16'h0000, 16'h0A00, 16'h0100, 16'hFFFF};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_SMOOTH_ENABLE, 16'(ph != 2));
            write_reg(REG_POS_SMOOTHNESS, ph < 4 ? rates[ph] : 16'($urandom));
            write_reg(REG_ROT_SMOOTHNESS, ph < 4 ? rates[3 - ph] : 16'($urandom));
            for (int i = 0; i < 250; i++) send_move(random_move($urandom_range(0, 3) != 0), 1'b1);
            wait_drained();
        end
        // Final stretch with no idling on either side.
        rx_idle_on = 1'b0;
        for (int i = 0; i < 250; i++) send_move(random_move(1'b1), 1'b0);
    endtask

    initial begin
        mdl_smooth = 1'b0;
        mdl_pos_rate = 16'd2560;
        mdl_rot_rate = 16'd2560;
        mdl_pos = '{0, 0, 0};
        mdl_ang = '{0, 0, 0};
        mdl_seeded = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_direct_extremes();
        test_smooth_snap_and_blend();
        test_backpressure_fill();
        test_random_phases();
        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[sim.f]
sv/sevm_pkg.sv
sv/sevm_ctrl.sv
sv/sevm_datapath.sv
sv/smoothed_euler_view_matrix.sv
test/tb_smoothed_euler_view_matrix.sv
